>>> sv/lsb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lsb_pkg: shared types and constants of the seam blender
// Field widths, register indexes, blend modes and the pixel type used by the
// lanes, the output queue and the top level.
// ============================================================================
package lsb_pkg;

   // Default column count of the left image and upper bound of left_width.
   localparam int MAX_WIDTH_DEFAULT = 4096;

   // Fixed field widths.
   localparam int PIX_BITS       = 8;
   localparam int COL_BITS       = 13;
   localparam int SEAM_BITS      = 12;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;

   // One lane per color channel.
   localparam int LANES = 3;

   // Lane stages: product stage, sum stage, one divider stage per result bit.
   localparam int LANE_LATENCY = 2 + PIX_BITS;

   // Output queue depth; it must exceed the pipeline latency for full rate.
   localparam int FIFO_DEPTH = 16;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type REG_SEAM_START = 2'd0;
   localparam csr_index_type REG_LEFT_WIDTH = 2'd1;

   typedef enum logic [1:0] {
      MODE_LEFT,
      MODE_WARP,
      MODE_BLEND
   } mode_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] red;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] blue;
   } pixel_type;

endpackage

>>> sv/lsb_if.sv
`timescale 1ns / 1ps
// ============================================================================
// lsb_req_if / lsb_rsp_if: pixel channels of the seam blender
// Valid/ready channels; a transfer happens at a rising edge with both high.
// ============================================================================
interface lsb_req_if;
   logic                          valid;
   logic                          ready;
   logic [lsb_pkg::COL_BITS-1:0]  column;
   logic [lsb_pkg::PIX_BITS-1:0]  left_red;
   logic [lsb_pkg::PIX_BITS-1:0]  left_green;
   logic [lsb_pkg::PIX_BITS-1:0]  left_blue;
   logic [lsb_pkg::PIX_BITS-1:0]  warp_red;
   logic [lsb_pkg::PIX_BITS-1:0]  warp_green;
   logic [lsb_pkg::PIX_BITS-1:0]  warp_blue;

   modport source (
      output valid, column, left_red, left_green, left_blue,
             warp_red, warp_green, warp_blue,
      input  ready
   );

   modport sink (
      input  valid, column, left_red, left_green, left_blue,
             warp_red, warp_green, warp_blue,
      output ready
   );
endinterface

interface lsb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lsb_pkg::PIX_BITS-1:0]  out_red;
   logic [lsb_pkg::PIX_BITS-1:0]  out_green;
   logic [lsb_pkg::PIX_BITS-1:0]  out_blue;

   modport source (
      output valid, out_red, out_green, out_blue,
      input  ready
   );

   modport sink (
      input  valid, out_red, out_green, out_blue,
      output ready
   );
endinterface

>>> sv/linear_seam_blend.sv
`timescale 1ns / 1ps
// ============================================================================
// linear_seam_blend: linear feather blend across a stitching seam
// Takes one output pixel with its left and warped RGB values and returns the
// stitched RGB pixel, feathered linearly inside the overlap.
// ============================================================================
// The block accepts one pixel per clock while input ready is high and returns
// one pixel per clock while the receiver takes them, with no dependence between
// pixels. After its transfer in, a pixel passes a stage that classifies the
// column; then each color channel runs in a lane of its own through a
// product stage, a sum stage and an eight-stage restoring divider that
// produces one quotient bit per stage. The sixteen-entry output queue lets
// the block keep taking pixels while results wait downstream; input ready
// drops only in reset or with sixteen pixels accepted but not delivered.
// Columns at or past left_width pass the warped pixel, columns before
// seam_start pass the left pixel, and columns inside the overlap give, per
// channel, floor((left*l + warp*(W-l))/W) with W = left_width - seam_start
// and l = left_width - column; a channel whose warped value is zero keeps the
// left value. Register 0 is seam_start, register 1 is left_width, which
// saturates at MAX_WIDTH; writes to other indexes are ignored. Registers are
// meant to be written only while no pixel is in flight.
module linear_seam_blend #(
   parameter int MAX_WIDTH = lsb_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   lsb_req_if.sink                             req,
   lsb_rsp_if.source                           rsp,
   input  logic                                csr_we,
   input  lsb_pkg::csr_index_type              csr_index,
   input  logic [lsb_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int PB       = lsb_pkg::PIX_BITS;
   localparam int LANES    = lsb_pkg::LANES;
   // The left width register must hold MAX_WIDTH itself.
   localparam int LW_BITS  = $clog2(MAX_WIDTH + 1);
   // Column compares run at the wider of the column and left width.
   localparam int CMP_BITS = (LW_BITS > lsb_pkg::COL_BITS) ? LW_BITS : lsb_pkg::COL_BITS;
   localparam int PIPE_LAT = 1 + lsb_pkg::LANE_LATENCY;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [lsb_pkg::SEAM_BITS-1:0] seam_ff;
   logic [lsb_pkg::SEAM_BITS-1:0] seam_in;
   logic [LW_BITS-1:0]            width_ff;
   logic [LW_BITS-1:0]            width_in;
   logic [LW_BITS-1:0]            span_ff;

   always_comb begin
      seam_in  = seam_ff;
      width_in = width_ff;
      if (csr_we) begin
         case (csr_index)
            lsb_pkg::REG_SEAM_START: begin
               seam_in = csr_wdata[lsb_pkg::SEAM_BITS-1:0];
            end
            lsb_pkg::REG_LEFT_WIDTH: begin
               // Widths beyond the largest supported image saturate.
               if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
                  width_in = LW_BITS'(MAX_WIDTH);
               end else begin
                  width_in = LW_BITS'(csr_wdata);
               end
            end
            default: begin
               seam_in  = seam_ff;
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seam_ff  <= '0;
         width_ff <= LW_BITS'(MAX_WIDTH);
      end else begin
         seam_ff  <= seam_in;
         width_ff <= width_in;
      end
   end

   // Overlap width W. It is only used for columns inside the overlap, where
   // seam_start < left_width and so W is at least one.
   always_ff @(posedge clock) begin
      span_ff <= LW_BITS'(CMP_BITS'(width_ff) - CMP_BITS'(seam_ff));
   end

   // ------------------------------------------------------------------------
   // Column classification stage
   // ------------------------------------------------------------------------
   logic                 room;
   logic                 req_acc;
   logic [CMP_BITS-1:0]  col_x;
   logic [CMP_BITS-1:0]  width_x;
   logic [CMP_BITS-1:0]  seam_x;
   lsb_pkg::mode_type    mode_in;

   logic                 a_vld_ff;
   lsb_pkg::mode_type    a_mode_ff;
   logic [LW_BITS-1:0]   a_near_ff;
   logic [LW_BITS-1:0]   a_far_ff;
   logic [PB-1:0]        a_left_ff [LANES];
   logic [PB-1:0]        a_warp_ff [LANES];

   assign req.ready = room && !reset;
   assign req_acc   = req.valid && req.ready;

   assign col_x   = CMP_BITS'(req.column);
   assign width_x = CMP_BITS'(width_ff);
   assign seam_x  = CMP_BITS'(seam_ff);

   // The past-the-left-image test wins over the before-the-seam test, so an
   // empty overlap never reaches the blend.
   always_comb begin
      if (col_x >= width_x) begin
         mode_in = lsb_pkg::MODE_WARP;
      end else if (col_x < seam_x) begin
         mode_in = lsb_pkg::MODE_LEFT;
      end else begin
         mode_in = lsb_pkg::MODE_BLEND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= req_acc;
      end
      a_mode_ff    <= mode_in;
      // Left weight l = left_width - column, warp weight W - l = column - seam.
      a_near_ff    <= LW_BITS'(width_x - col_x);
      a_far_ff     <= LW_BITS'(col_x - seam_x);
      a_left_ff[0] <= req.left_red;
      a_left_ff[1] <= req.left_green;
      a_left_ff[2] <= req.left_blue;
      a_warp_ff[0] <= req.warp_red;
      a_warp_ff[1] <= req.warp_green;
      a_warp_ff[2] <= req.warp_blue;
   end

   // ------------------------------------------------------------------------
   // Channel lanes
   // ------------------------------------------------------------------------
   logic [LANES-1:0] lane_vld;
   logic [PB-1:0]    lane_val [LANES];

   for (genvar c = 0; c < LANES; c++) begin : g_lane
      lsb_lane #(
         .LW_BITS (LW_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (a_vld_ff),
         .in_mode   (a_mode_ff),
         .in_near   (a_near_ff),
         .in_far    (a_far_ff),
         .in_span   (span_ff),
         .in_left   (a_left_ff[c]),
         .in_warp   (a_warp_ff[c]),
         .out_valid (lane_vld[c]),
         .out_value (lane_val[c])
      );
   end

   // ------------------------------------------------------------------------
   // Merge of the lanes into the output queue
   // ------------------------------------------------------------------------
   lsb_pkg::pixel_type lane_pixel;

   assign lane_pixel.red   = lane_val[0];
   assign lane_pixel.green = lane_val[1];
   assign lane_pixel.blue  = lane_val[2];

   lsb_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .take       (req_acc),
      .lane_valid (lane_vld[0]),
      .lane_pixel (lane_pixel),
      .room       (room),
      .rsp        (rsp)
   );

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // The lanes run in lockstep, so their results always arrive together.
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (lane_vld == '0) || (lane_vld == '1))
      else $error("lane results out of step");

   // Every accepted pixel reaches the queue once it has passed classification and the lanes.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> ##PIPE_LAT lane_vld[0])
      else $error("accepted pixel did not reach the output queue");

   // Nothing but an accepted pixel reaches the queue.
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      lane_vld[0] |-> $past(req_acc, PIPE_LAT))
      else $error("lane result does not match an accepted pixel");

   // The left width register never holds more than the largest image width.
   a_width_clamped: assert property (@(posedge clock) disable iff (reset)
      32'(width_ff) <= 32'(MAX_WIDTH))
      else $error("left width register above its maximum");

endmodule

>>> sv/lsb_lane.sv
`timescale 1ns / 1ps
// ============================================================================
// lsb_lane: feather blend of one color channel
// Two weighted products, their sum, then a pipelined restoring divider that
// retires one quotient bit per stage. Pass-through values ride alongside.
// ============================================================================
module lsb_lane #(
   parameter int LW_BITS = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  lsb_pkg::mode_type             in_mode,
   input  logic [LW_BITS-1:0]            in_near,
   input  logic [LW_BITS-1:0]            in_far,
   input  logic [LW_BITS-1:0]            in_span,
   input  logic [lsb_pkg::PIX_BITS-1:0]  in_left,
   input  logic [lsb_pkg::PIX_BITS-1:0]  in_warp,
   output logic                          out_valid,
   output logic [lsb_pkg::PIX_BITS-1:0]  out_value
);

   localparam int PB       = lsb_pkg::PIX_BITS;
   localparam int NUM_BITS = LW_BITS + PB;

   // Product stage.
   logic                p_vld_ff;
   logic [NUM_BITS-1:0] p_left_ff;
   logic [NUM_BITS-1:0] p_warp_ff;
   logic                p_pass_ff;
   logic [PB-1:0]       p_pval_ff;
   logic                pass_in;
   logic [PB-1:0]       pval_in;

   // Index 0 holds the sum; index k holds the remainder after quotient bit k.
   logic                vld_ff  [PB+1];
   logic [NUM_BITS-1:0] rem_ff  [PB+1];
   logic [PB-1:0]       quo_ff  [PB+1];
   logic                pass_ff [PB+1];
   logic [PB-1:0]       pval_ff [PB+1];
   logic [NUM_BITS-1:0] rem_in  [PB+1];
   logic [PB-1:0]       quo_in  [PB+1];

   // A channel without warp coverage keeps its left value even in the overlap.
   always_comb begin
      case (in_mode)
         lsb_pkg::MODE_LEFT: begin
            pass_in = 1'b1;
            pval_in = in_left;
         end
         lsb_pkg::MODE_WARP: begin
            pass_in = 1'b1;
            pval_in = in_warp;
         end
         lsb_pkg::MODE_BLEND: begin
            pass_in = (in_warp == '0);
            pval_in = in_left;
         end
         default: begin
            pass_in = 1'b1;
            pval_in = in_left;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= in_valid;
      end
      p_left_ff <= NUM_BITS'(in_left) * NUM_BITS'(in_near);
      p_warp_ff <= NUM_BITS'(in_warp) * NUM_BITS'(in_far);
      p_pass_ff <= pass_in;
      p_pval_ff <= pval_in;
   end

   // The sum is below 256 times the span, so it fits NUM_BITS.
   assign rem_in[0] = p_left_ff + p_warp_ff;
   assign quo_in[0] = '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= p_vld_ff;
      end
      rem_ff[0]  <= rem_in[0];
      quo_ff[0]  <= quo_in[0];
      pass_ff[0] <= p_pass_ff;
      pval_ff[0] <= p_pval_ff;
   end

   for (genvar k = 1; k <= PB; k++) begin : g_div
      logic [NUM_BITS-1:0] trial;
      logic                fits;

      always_comb begin
         trial     = NUM_BITS'(in_span) << (PB - k);
         fits      = (rem_ff[k-1] >= trial);
         rem_in[k] = fits ? (rem_ff[k-1] - trial) : rem_ff[k-1];
         quo_in[k] = {quo_ff[k-1][PB-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rem_ff[k]  <= rem_in[k];
         quo_ff[k]  <= quo_in[k];
         pass_ff[k] <= pass_ff[k-1];
         pval_ff[k] <= pval_ff[k-1];
      end
   end

   assign out_valid = vld_ff[PB];
   assign out_value = pass_ff[PB] ? pval_ff[PB] : quo_ff[PB];

endmodule

>>> sv/lsb_merge.sv
`timescale 1ns / 1ps
// ============================================================================
// lsb_merge: output queue of the seam blender
// Joins the three lane results into one pixel, queues it and keeps a credit
// count of pixels accepted but not yet delivered.
// ============================================================================
module lsb_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic                lane_valid,
   input  lsb_pkg::pixel_type  lane_pixel,
   output logic                room,
   lsb_rsp_if.source           rsp
);

   localparam int DEPTH    = lsb_pkg::FIFO_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   lsb_pkg::pixel_type  queue_ff [DEPTH];
   logic [PTR_BITS:0]   wr_ptr_ff;
   logic [PTR_BITS:0]   rd_ptr_ff;
   logic [CNT_BITS-1:0] credit_ff;
   logic [CNT_BITS-1:0] credit_in;
   logic                deliver;
   lsb_pkg::pixel_type  head;

   assign deliver = rsp.valid && rsp.ready;
   assign room    = (credit_ff < CNT_BITS'(DEPTH));

   always_comb begin
      credit_in = credit_ff;
      if (take && !deliver) begin
         credit_in = credit_ff + 1'b1;
      end else if (!take && deliver) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
         if (lane_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (deliver) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (lane_valid) begin
         queue_ff[wr_ptr_ff[PTR_BITS-1:0]] <= lane_pixel;
      end
   end

   assign head          = queue_ff[rd_ptr_ff[PTR_BITS-1:0]];
   assign rsp.valid     = (wr_ptr_ff != rd_ptr_ff);
   assign rsp.out_red   = head.red;
   assign rsp.out_green = head.green;
   assign rsp.out_blue  = head.blue;

endmodule

>>> test/seam_blend_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// seam_blend_checker: scoreboard for the linear seam blender
// Mirrors the seam registers from the write port, works out the stitched
// pixel for every accepted input transfer and compares each output transfer
// with the oldest pixel still owed.
// ============================================================================
module seam_blend_checker (
   input  logic                               clock,
   input  logic                               reset,
   lsb_req_if                                 req,
   lsb_rsp_if                                 rsp,
   input  logic                               csr_we,
   input  lsb_pkg::csr_index_type             csr_index,
   input  logic [lsb_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                 mismatch_count,
   output int                                 pending_count,
   output int                                 checked_count
);

   localparam int WIDTH_LIMIT = lsb_pkg::MAX_WIDTH_DEFAULT;
   localparam int PB          = lsb_pkg::PIX_BITS;
   localparam int CB          = lsb_pkg::COL_BITS;
   localparam int SB          = lsb_pkg::SEAM_BITS;

   logic [SB-1:0]        cfg_seam;
   logic [CB-1:0]        cfg_width;
   lsb_pkg::pixel_type   owed_pixels[$];
   int                   errors;
   int                   checked;

   initial begin
      cfg_seam  = '0;
      cfg_width = CB'(WIDTH_LIMIT);
      errors    = 0;
      checked   = 0;
   end

   // Inside the overlap: l = width - column, W - l = column - seam.
   function automatic logic [PB-1:0] feather_channel(logic [PB-1:0] lv,
                                                     logic [PB-1:0] wv,
                                                     logic [CB-1:0] col);
      int span;
      int weight;
      int total;
      if (wv == '0)
         return lv;
      span   = int'(cfg_width) - int'(cfg_seam);
      weight = int'(cfg_width) - int'(col);
      total  = int'(lv) * weight + int'(wv) * (span - weight);
      return PB'(total / span);
   endfunction

   function automatic lsb_pkg::pixel_type stitch_pixel(logic [CB-1:0] col,
                                                       lsb_pkg::pixel_type left_px,
                                                       lsb_pkg::pixel_type warp_px);
      lsb_pkg::pixel_type blended;
      if (col >= cfg_width) begin
         blended = warp_px;
      end else if (col < CB'(cfg_seam)) begin
         blended = left_px;
      end else begin
         blended.red   = feather_channel(left_px.red,   warp_px.red,   col);
         blended.green = feather_channel(left_px.green, warp_px.green, col);
         blended.blue  = feather_channel(left_px.blue,  warp_px.blue,  col);
      end
      return blended;
   endfunction

   always @(posedge clock) begin
      lsb_pkg::pixel_type want;
      lsb_pkg::pixel_type left_px;
      lsb_pkg::pixel_type warp_px;
      if (reset) begin
         owed_pixels.delete();
         cfg_seam  = '0;
         cfg_width = CB'(WIDTH_LIMIT);
      end else begin
         if (rsp.valid && rsp.ready) begin
            checked++;
            if (owed_pixels.size() == 0) begin
               $error("stitched pixel %0d/%0d/%0d arrived with nothing owed",
                      rsp.out_red, rsp.out_green, rsp.out_blue);
               errors++;
            end else begin
               want = owed_pixels.pop_front();
               if (rsp.out_red !== want.red) begin
                  $error("out_red: expected %0d, got %0d", want.red, rsp.out_red);
                  errors++;
               end
               if (rsp.out_green !== want.green) begin
                  $error("out_green: expected %0d, got %0d", want.green, rsp.out_green);
                  errors++;
               end
               if (rsp.out_blue !== want.blue) begin
                  $error("out_blue: expected %0d, got %0d", want.blue, rsp.out_blue);
                  errors++;
               end
            end
         end
         if (req.valid && req.ready) begin
            left_px = '{req.left_red, req.left_green, req.left_blue};
            warp_px = '{req.warp_red, req.warp_green, req.warp_blue};
            owed_pixels = {owed_pixels, stitch_pixel(req.column, left_px, warp_px)};
         end
         if (csr_we) begin
            case (csr_index)
               lsb_pkg::REG_SEAM_START: cfg_seam = csr_wdata[SB-1:0];
               lsb_pkg::REG_LEFT_WIDTH: begin
                  if (int'(csr_wdata) > WIDTH_LIMIT)
                     cfg_width = CB'(WIDTH_LIMIT);
                  else
                     cfg_width = csr_wdata;
               end
               default: ;
            endcase
         end
      end
      mismatch_count <= errors;
      pending_count  <= owed_pixels.size();
      checked_count  <= checked;
   end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: stimulus and verdict for the linear seam blender
// Writes a series of seam settings, streams pixels through the blender with
// random gaps and output stalls, and lets the scoreboard judge every result.
// ============================================================================
module testbench;

   // Writes to these indexes must leave both seam registers untouched.
   localparam lsb_pkg::csr_index_type REG_SPARE_2 = 2'd2;
   localparam lsb_pkg::csr_index_type REG_SPARE_3 = 2'd3;

   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 236;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int CB             = lsb_pkg::COL_BITS;
   localparam int DB             = lsb_pkg::CSR_DATA_BITS;
   localparam int PB             = lsb_pkg::PIX_BITS;
   localparam int SB             = lsb_pkg::SEAM_BITS;
   localparam int WIDTH_MAX      = lsb_pkg::MAX_WIDTH_DEFAULT;
   localparam int COL_MAX        = (1 << CB) - 1;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   lsb_pkg::csr_index_type    csr_index;
   logic [DB-1:0]             csr_wdata;

   int mismatch_count;
   int pending_count;
   int checked_count;

   // When cleared, both sides run flat out with no gaps and no stalls.
   bit idle_on = 1'b1;

   // Column window that the random stimulus aims at: the overlap and its edges.
   int aim_seam;
   int aim_width;

   int pixels_sent;
   int settings_done;
   int quiet_cycles;

   lsb_req_if req_ch ();
   lsb_rsp_if rsp_ch ();

   linear_seam_blend u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   seam_blend_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // The watchdog counts cycles in which neither channel makes a transfer. The
   // longest quiet stretch in a correct run is the pipeline latency plus a
   // stall, or a few register writes; the limit is far above that.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: after each transfer out, ready drops for a randomly drawn stall while idling is on.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            rsp_ch.ready <= (stall == 0);
         end else if (stall > 0) begin
            stall = stall - 1;
            rsp_ch.ready <= (stall == 0);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // A register write ends with a clock wait after the enable drops, so the enable
   // never rises and falls in the same time step.
   task automatic write_reg(lsb_pkg::csr_index_type idx, logic [DB-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Writes both seam registers and keeps the aiming window in step. The
   // width register saturates at the largest image width.
   task automatic set_seam(int seam_data, int width_data);
      write_reg(lsb_pkg::REG_SEAM_START, DB'(seam_data));
      write_reg(lsb_pkg::REG_LEFT_WIDTH, DB'(width_data));
      aim_seam  = seam_data % (1 << SB);
      aim_width = (width_data > WIDTH_MAX) ? WIDTH_MAX : width_data;
      settings_done++;
   endtask

   // Sends one pixel. Valid stays high from one transfer to the next when no
   // gap is drawn, so it is never lowered and raised in one step.
   task automatic send_pixel(int col, lsb_pkg::pixel_type left_px,
                             lsb_pkg::pixel_type warp_px);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.column     <= CB'(col);
      req_ch.left_red   <= left_px.red;
      req_ch.left_green <= left_px.green;
      req_ch.left_blue  <= left_px.blue;
      req_ch.warp_red   <= warp_px.red;
      req_ch.warp_green <= warp_px.green;
      req_ch.warp_blue  <= warp_px.blue;
      do @(posedge clock); while (!req_ch.ready);
      pixels_sent++;
   endtask

   // Registers may only change with nothing in flight, so every change of
   // setting first waits for the scoreboard to have nothing owed.
   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // A channel value: the two extremes show up often, the rest is uniform.
   // Warped channels are zero more often, since zero means no coverage.
   function automatic logic [PB-1:0] random_channel(int zero_odds);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < zero_odds)
         return '0;
      else if (pick < zero_odds + 10)
         return '1;
      else
         return PB'($urandom);
   endfunction

   function automatic lsb_pkg::pixel_type random_pixel(int zero_odds);
      lsb_pkg::pixel_type px;
      px.red   = random_channel(zero_odds);
      px.green = random_channel(zero_odds);
      px.blue  = random_channel(zero_odds);
      return px;
   endfunction

   // Two thirds of the columns land in or just around the overlap, the rest
   // anywhere in the full column range.
   function automatic int random_column();
      int lo;
      int hi;
      if ($urandom_range(0, 2) == 0)
         return $urandom_range(0, COL_MAX);
      lo = ((aim_seam < aim_width) ? aim_seam : aim_width) - 3;
      hi = ((aim_seam > aim_width) ? aim_seam : aim_width) + 3;
      if (lo < 0)
         lo = 0;
      if (hi > COL_MAX)
         hi = COL_MAX;
      return $urandom_range(lo, hi);
   endfunction

   // Directed part: the seam edges, both pass-through regions, the feather at
   // full and minimal weight, missing warp coverage, an empty overlap, a zero
   // width, a saturating width and writes to unused register indexes.
   task automatic run_directed();
      set_seam(100, 200);
      send_pixel(0,     '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255});
      send_pixel(99,    '{8'd255, 8'd255, 8'd255}, '{8'd1,   8'd1,   8'd1});
      send_pixel(100,   '{8'd10,  8'd20,  8'd30},  '{8'd200, 8'd100, 8'd50});
      send_pixel(150,   '{8'd255, 8'd0,   8'd255}, '{8'd0,   8'd255, 8'd1});
      send_pixel(199,   '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255});
      send_pixel(199,   '{8'd77,  8'd88,  8'd99},  '{8'd0,   8'd0,   8'd0});
      send_pixel(200,   '{8'd255, 8'd255, 8'd255}, '{8'd0,   8'd128, 8'd255});
      send_pixel(4096,  '{8'd1,   8'd2,   8'd3},   '{8'd4,   8'd5,   8'd6});
      send_pixel(COL_MAX, '{8'd255, 8'd255, 8'd255}, '{8'd0, 8'd0,   8'd0});
      drain_pipeline();

      // All upper data bits set: the seam keeps its 12 bits, the width
      // saturates, which leaves an overlap one column wide.
      set_seam(COL_MAX, COL_MAX);
      send_pixel(4094, '{8'd11,  8'd22, 8'd33},  '{8'd44, 8'd55, 8'd66});
      send_pixel(4095, '{8'd255, 8'd0,  8'd128}, '{8'd1,  8'd255, 8'd0});
      send_pixel(4096, '{8'd255, 8'd0,  8'd128}, '{8'd1,  8'd255, 8'd0});
      drain_pipeline();

      // Seam past the width: nothing blends.
      set_seam(300, 200);
      send_pixel(199, '{8'd9, 8'd8, 8'd7}, '{8'd6, 8'd5, 8'd4});
      send_pixel(200, '{8'd9, 8'd8, 8'd7}, '{8'd6, 8'd5, 8'd4});
      send_pixel(250, '{8'd9, 8'd8, 8'd7}, '{8'd0, 8'd5, 8'd4});
      send_pixel(300, '{8'd9, 8'd8, 8'd7}, '{8'd6, 8'd5, 8'd4});
      drain_pipeline();

      // Zero width: even column zero takes the warped pixel.
      set_seam(0, 0);
      send_pixel(0, '{8'd200, 8'd150, 8'd100}, '{8'd50, 8'd25, 8'd0});
      drain_pipeline();

      // A full-width overlap, then writes to the unused indexes. Column ten
      // tells a blend apart from either register having been hit.
      set_seam(0, WIDTH_MAX);
      write_reg(REG_SPARE_2, DB'(COL_MAX));
      write_reg(REG_SPARE_3, '0);
      send_pixel(10,   '{8'd200, 8'd200, 8'd200}, '{8'd100, 8'd100, 8'd100});
      send_pixel(4095, '{8'd0,   8'd255, 8'd17},  '{8'd255, 8'd1,   8'd34});
      drain_pipeline();
   endtask

   // Each random phase starts from a fresh setting; the first three and the
   // zero width are the extremes, the rest are drawn.
   task automatic pick_setting(int phase);
      int seam_data;
      int width_data;
      case (phase)
         0: begin
            seam_data  = 0;
            width_data = WIDTH_MAX;
         end
         1: begin
            seam_data  = COL_MAX;
            width_data = WIDTH_MAX;
         end
         2: begin
            seam_data  = 0;
            width_data = 1;
         end
         3: begin
            width_data = $urandom_range(2, WIDTH_MAX);
            seam_data  = $urandom_range(0, width_data - 1);
         end
         4: begin
            seam_data  = $urandom_range(0, COL_MAX);
            width_data = $urandom_range(0, COL_MAX);
         end
         5: begin
            width_data = $urandom_range(1, 4000);
            seam_data  = $urandom_range(width_data, (1 << SB) - 1);
         end
         6: begin
            seam_data  = $urandom_range(0, COL_MAX);
            width_data = 0;
         end
         default: begin
            seam_data  = $urandom_range(0, 4000);
            width_data = seam_data + $urandom_range(1, 16);
         end
      endcase
      set_seam(seam_data, width_data);
      if ($urandom_range(0, 1) == 1)
         write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                   DB'($urandom));
   endtask

   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = lsb_pkg::REG_SEAM_START;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.column     = '0;
      req_ch.left_red   = '0;
      req_ch.left_green = '0;
      req_ch.left_blue  = '0;
      req_ch.warp_red   = '0;
      req_ch.warp_green = '0;
      req_ch.warp_blue  = '0;
      pixels_sent       = 0;
      settings_done     = 0;
      quiet_cycles      = 0;
      aim_seam          = 0;
      aim_width         = WIDTH_MAX;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Random phases. Idling flips now and then, so some stretches run at
      // full rate on both sides and others have gaps everywhere.
      for (int phase = 0; phase < PHASES; phase++) begin
         pick_setting(phase);
         idle_on = (phase % 2 == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0)
               idle_on = !idle_on;
            send_pixel(random_column(), random_pixel(3), random_pixel(15));
         end
         drain_pipeline();
      end

      // Everything owed has arrived; give a stray late transfer time to show.
      repeat (lsb_pkg::LANE_LATENCY + 8) @(posedge clock);

      $display("Sent %0d pixels under %0d seam settings, %0d stitched pixels compared.",
               pixels_sent, settings_done, checked_count);
      $display("Both sides ran with and without random gaps and stalls.");
      if (mismatch_count == 0 && pending_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

>>> sim.f
sv/lsb_pkg.sv
sv/lsb_if.sv
sv/lsb_lane.sv
sv/lsb_merge.sv
sv/linear_seam_blend.sv
test/seam_blend_checker.sv
test/testbench.sv
